@@ src/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/bmaff_pkg.sv @@
`timescale 1ns / 1ps

package bmaff_pkg;

    localparam int IDX_W    = 12;
    localparam int COUNT_W  = 13;
    localparam int NB_W     = COUNT_W - 3;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam cmd_t CMD_SET   = 2'd0;
    localparam cmd_t CMD_CLEAR = 2'd1;
    localparam cmd_t CMD_READ  = 2'd2;
    localparam cmd_t CMD_FIND  = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_RANGE = 2'd1;
    localparam status_t ST_NONE  = 2'd2;

    localparam logic [7:0] FULL_BYTE = 8'hff;

    typedef struct packed {
        logic             bit_value;
        logic [IDX_W-1:0] found_index;
        status_t          status;
    } result_t;

    // Position of the lowest clear bit of a byte that is not all ones.
    function automatic logic [2:0] first_zero(input logic [7:0] b);
        logic [2:0] pos;
        pos = '0;
        for (int k = 7; k >= 0; k--) begin
            if (!b[k]) begin
                pos = 3'(k);
            end
        end
        return pos;
    endfunction

endpackage

@@ src/bmaff_store.sv @@
`timescale 1ns / 1ps

module bmaff_store #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/bmaff_seq.sv @@
`timescale 1ns / 1ps

module bmaff_seq #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [bmaff_pkg::COUNT_W-1:0]     used_bits,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  bmaff_pkg::cmd_t                   s_command,
    input  logic [bmaff_pkg::IDX_W-1:0]       s_bit_index,
    output logic                              res_valid,
    input  logic                              res_ready,
    output bmaff_pkg::result_t                res,
    output logic                              mem_wr_en,
    output logic [ADDR_W-1:0]                 mem_wr_addr,
    output logic [7:0]                        mem_wr_data,
    output logic [ADDR_W-1:0]                 mem_rd_addr,
    input  logic [7:0]                        mem_rd_data
);

    localparam int SCAN_W = (ADDR_W > bmaff_pkg::NB_W) ? ADDR_W : bmaff_pkg::NB_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]                        state_reg, state_next;
    logic [SCAN_W-1:0]                 cnt_reg, cnt_next;
    bmaff_pkg::cmd_t                   cmd_reg, cmd_next;
    logic [bmaff_pkg::IDX_W-1:0]       idx_reg, idx_next;
    bmaff_pkg::result_t                res_reg, res_next;

    logic [SCAN_W-1:0]                 cnt_inc;
    logic [SCAN_W-1:0]                 rd_sel;
    logic [SCAN_W-1:0]                 acc_byte;
    logic [SCAN_W-1:0]                 nbytes;
    logic [SCAN_W+2:0]                 found_wide;
    logic [7:0]                        bit_mask;

    assign cnt_inc    = SCAN_W'(cnt_reg + 1'b1);
    assign acc_byte   = SCAN_W'(idx_reg[bmaff_pkg::IDX_W-1:3]);
    assign nbytes     = SCAN_W'(used_bits[bmaff_pkg::COUNT_W-1:3]);
    assign found_wide = {cnt_reg, bmaff_pkg::first_zero(mem_rd_data)};
    assign bit_mask   = 8'(1) << idx_reg[2:0];

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd_next    = cmd_reg;
        idx_next    = idx_reg;
        res_next    = res_reg;
        rd_sel      = cnt_inc;
        mem_wr_en   = 1'b0;
        mem_wr_addr = acc_byte[ADDR_W-1:0];
        mem_wr_data = mem_rd_data;

        unique case (state_reg)
            S_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = cnt_reg[ADDR_W-1:0];
                mem_wr_data = '0;
                if (cnt_reg == SCAN_W'(DEPTH - 1)) begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            S_IDLE: begin
                rd_sel = SCAN_W'(s_bit_index[bmaff_pkg::IDX_W-1:3]);
                if (s_valid) begin
                    cmd_next = s_command;
                    idx_next = s_bit_index;
                    res_next = '0;
                    if (s_command == bmaff_pkg::CMD_FIND) begin
                        rd_sel   = '0;
                        cnt_next = '0;
                        if (nbytes == '0) begin
                            res_next.status = bmaff_pkg::ST_NONE;
                            state_next      = S_FIN;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end else if ({1'b0, s_bit_index} >= used_bits) begin
                        res_next.status = bmaff_pkg::ST_RANGE;
                        state_next      = S_FIN;
                    end else begin
                        state_next = S_ACC;
                    end
                end
            end
            S_ACC: begin
                unique case (cmd_reg)
                    bmaff_pkg::CMD_SET: begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = mem_rd_data | bit_mask;
                    end
                    bmaff_pkg::CMD_CLEAR: begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = mem_rd_data & ~bit_mask;
                    end
                    default: begin
                        res_next.bit_value = mem_rd_data[idx_reg[2:0]];
                    end
                endcase
                state_next = S_FIN;
            end
            S_SCAN: begin
                if (mem_rd_data != bmaff_pkg::FULL_BYTE) begin
                    res_next.found_index = found_wide[bmaff_pkg::IDX_W-1:0];
                    state_next           = S_FIN;
                end else if (cnt_inc == nbytes) begin
                    res_next.status = bmaff_pkg::ST_NONE;
                    state_next      = S_FIN;
                end else begin
                    cnt_next = cnt_inc;
                end
            end
            S_FIN: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
    end

    assign s_ready     = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_FIN);
    assign res         = res_reg;
    assign mem_rd_addr = rd_sel[ADDR_W-1:0];

endmodule

@@ src/bitmap_allocator_first_free_unit.sv @@
`timescale 1ns / 1ps
// Allocation bitmap of MAX_BITS bits with a lowest-free-bit search.
// The input channel (s_valid, s_ready) carries a command and a bit index; every
// transfer produces exactly one result on the output channel (m_valid, m_ready)
// with the read bit, the found index and a status. cfg_wr_en writes the count of
// bits in use from cfg_wr_data; the user must write it only while the block is
// idle, and the block itself does not enforce this. Set, clear and read pass
// through S_ACC and S_FIN to the output register; an index out of range, or a
// find with no bits in use, goes from S_IDLE straight to S_FIN. A find reads one
// byte of the map per cycle through the single read port of the store, from byte
// 0 up to and including the first byte that has a clear bit, or up to the last
// byte in use. Items are handled one at a time: after each item, s_ready returns
// high only as its result moves into the output register. After reset the block
// sweeps all MAX_BITS/8 bytes of the store to zero, one byte per cycle; s_ready
// stays low meanwhile. Reset also restores the bit count to 4096. When the
// receiver stalls, the result waits in the output register; the block takes one
// more input item and holds its result until the output register is free.

module bitmap_allocator_first_free_unit #(
    parameter int MAX_BITS = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [bmaff_pkg::COUNT_W-1:0]       cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bmaff_pkg::CMD_W-1:0]         s_command,
    input  logic [bmaff_pkg::IDX_W-1:0]         s_bit_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_bit_value,
    output logic [bmaff_pkg::IDX_W-1:0]         m_found_index,
    output logic [bmaff_pkg::STATUS_W-1:0]      m_status
);

    localparam int DEPTH    = MAX_BITS / 8;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_BITS = DEPTH * 8;
    localparam logic [bmaff_pkg::COUNT_W-1:0] CAP_LIM =
        (CAP_BITS >= 8184) ? 13'd8184 : bmaff_pkg::COUNT_W'(CAP_BITS);

    logic [bmaff_pkg::COUNT_W-1:0] bit_count_reg;
    logic [bmaff_pkg::COUNT_W-1:0] count_masked;
    logic [bmaff_pkg::COUNT_W-1:0] used_bits;

    logic                res_valid;
    logic                res_ready;
    bmaff_pkg::result_t  res;

    logic                m_valid_reg;
    bmaff_pkg::result_t  m_result_reg;

    logic                mem_wr_en;
    logic [ADDR_W-1:0]   mem_wr_addr;
    logic [7:0]          mem_wr_data;
    logic [ADDR_W-1:0]   mem_rd_addr;
    logic [7:0]          mem_rd_data;

    assign count_masked = {bit_count_reg[bmaff_pkg::COUNT_W-1:3], 3'b000};
    assign used_bits    = (count_masked > CAP_LIM) ? CAP_LIM : count_masked;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_count_reg <= 13'd4096;
        end else if (cfg_wr_en) begin
            bit_count_reg <= cfg_wr_data;
        end
    end

    bmaff_seq #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .used_bits   (used_bits),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_bit_index (s_bit_index),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    bmaff_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_result_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_bit_value   = m_result_reg.bit_value;
    assign m_found_index = m_result_reg.found_index;
    assign m_status      = m_result_reg.status;

endmodule

@@ src/bmaff_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmaff_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic                                m_bit_value,
    input logic [bmaff_pkg::IDX_W-1:0]         m_found_index,
    input logic [bmaff_pkg::STATUS_W-1:0]      m_status
);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_bit_value) && $stable(m_found_index) && $stable(m_status),
        "Stalled result changed before its transfer.")

    `ASSERT_SAME(a_err_zero, aclk, aresetn, m_valid && (m_status != bmaff_pkg::ST_OK),
        !m_bit_value && (m_found_index == '0),
        "An error result carries a nonzero bit value or index.")

    `ASSERT_SAME(a_fields_excl, aclk, aresetn, m_valid && m_bit_value,
        (m_found_index == '0) && (m_status == bmaff_pkg::ST_OK),
        "A read result also carries a found index or an error.")

    `ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready,
        "A second input transfer was offered right after an accepted item.")

    `ASSERT_SAME(a_status_code, aclk, aresetn, m_valid,
        (m_status == bmaff_pkg::ST_OK) || (m_status == bmaff_pkg::ST_RANGE) ||
        (m_status == bmaff_pkg::ST_NONE),
        "Result status outside the defined codes.")

endmodule

bind bitmap_allocator_first_free_unit bmaff_checker u_bmaff_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_bit_value   (m_bit_value),
    .m_found_index (m_found_index),
    .m_status      (m_status)
);

@@ tb/bitmap_allocator_first_free_unit_tb.sv @@
`timescale 1ns / 1ps

module bitmap_allocator_first_free_unit_tb;
    import bmaff_pkg::*;

    localparam int STORE_BYTES = 512;
    localparam int CAPACITY = STORE_BYTES * 8;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 190;
    localparam int N_PHASES = 10;

    typedef struct packed {
        bit                 is_cfg;
        logic [COUNT_W-1:0] cfg_value;
        cmd_t               cmd;
        logic [IDX_W-1:0]   idx;
        bit                 typed;
        result_t            want;
    } dir_row_t;

    localparam dir_row_t DIRECTED [27] = '{
        '{1'b0, 13'd0, CMD_READ, 12'd0, 1'b1, '{1'b0, 12'd0, ST_OK}},
        '{1'b0, 13'd0, CMD_READ, 12'd4095, 1'b1, '{1'b0, 12'd0, ST_OK}},
        '{1'b0, 13'd0, CMD_FIND, 12'd4095, 1'b1, '{1'b0, 12'd0, ST_OK}},
        '{1'b0, 13'd0, CMD_SET, 12'd0, 1'b1, '{1'b0, 12'd0, ST_OK}},
        '{1'b0, 13'd0, CMD_FIND, 12'd0, 1'b0, '{1'b0, 12'd0, ST_OK}},
        '{1'b0, 13'd0, CMD_SET, 12'd4095, 1'b1, '{1'b0, 12'd0, ST_OK}},
        '{1'b0, 13'd0, CMD_READ, 12'd4095, 1'b0, '{1'b0, 12'd0, ST_OK}},
        '{1'b0, 13'd0, CMD_CLEAR, 12'd0, 1'b1, '{1'b0, 12'd0, ST_OK}},
        '{1'b0, 13'd0, CMD_FIND, 12'd2048, 1'b0, '{1'b0, 12'd0, ST_OK}},
        '{1'b1, 13'd15, CMD_SET, 12'd0, 1'b0, '{1'b0, 12'd0, ST_OK}},
        '{1'b0, 13'd0, CMD_READ, 12'd8, 1'b1, '{1'b0, 12'd0, ST_RANGE}},
        '{1'b0, 13'd0, CMD_CLEAR, 12'd4095, 1'b1, '{1'b0, 12'd0, ST_RANGE}},
        '{1'b0, 13'd0, CMD_SET, 12'd0, 1'b0, '{1'b0, 12'd0, ST_OK}},
        '{1'b0, 13'd0, CMD_SET, 12'd1, 1'b0, '{1'b0, 12'd0, ST_OK}},
        '{1'b0, 13'd0, CMD_SET, 12'd2, 1'b0, '{1'b0, 12'd0, ST_OK}},
        '{1'b0, 13'd0, CMD_SET, 12'd3, 1'b0, '{1'b0, 12'd0, ST_OK}},
        '{1'b0, 13'd0, CMD_SET, 12'd4, 1'b0, '{1'b0, 12'd0, ST_OK}},
        '{1'b0, 13'd0, CMD_SET, 12'd5, 1'b0, '{1'b0, 12'd0, ST_OK}},
        '{1'b0, 13'd0, CMD_SET, 12'd6, 1'b0, '{1'b0, 12'd0, ST_OK}},
        '{1'b0, 13'd0, CMD_SET, 12'd7, 1'b0, '{1'b0, 12'd0, ST_OK}},
        '{1'b0, 13'd0, CMD_FIND, 12'd0, 1'b1, '{1'b0, 12'd0, ST_NONE}},
        '{1'b1, 13'd7, CMD_SET, 12'd0, 1'b0, '{1'b0, 12'd0, ST_OK}},
        '{1'b0, 13'd0, CMD_READ, 12'd0, 1'b1, '{1'b0, 12'd0, ST_RANGE}},
        '{1'b0, 13'd0, CMD_FIND, 12'd0, 1'b1, '{1'b0, 12'd0, ST_NONE}},
        '{1'b1, 13'h1fff, CMD_SET, 12'd0, 1'b0, '{1'b0, 12'd0, ST_OK}},
        '{1'b0, 13'd0, CMD_FIND, 12'd0, 1'b0, '{1'b0, 12'd0, ST_OK}},
        '{1'b0, 13'd0, CMD_READ, 12'd4095, 1'b0, '{1'b0, 12'd0, ST_OK}}
    };

    logic aclk;
    logic aresetn;
    logic cfg_wr_en;
    logic [COUNT_W-1:0] cfg_wr_data;
    logic s_valid;
    logic s_ready;
    logic [CMD_W-1:0] s_command;
    logic [IDX_W-1:0] s_bit_index;
    logic m_valid;
    logic m_ready;
    logic m_bit_value;
    logic [IDX_W-1:0] m_found_index;
    logic [STATUS_W-1:0] m_status;

    logic [7:0] alloc_map [STORE_BYTES];
    logic [COUNT_W-1:0] model_count;
    result_t pending_results [$];
    bit steady;
    int errors;
    int items_sent;
    int results_seen;
    int finds_seen;
    int none_free_seen;
    int range_seen;
    int idle_cycles;
    int stall_left;

    bitmap_allocator_first_free_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_bit_index  (s_bit_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_bit_value  (m_bit_value),
        .m_found_index(m_found_index),
        .m_status     (m_status)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    function automatic int bits_used();
        int n;
        n = int'({model_count[COUNT_W-1:3], 3'b000});
        if (n > CAPACITY) begin
            n = CAPACITY;
        end
        return n;
    endfunction

    function automatic result_t bitmap_apply(input cmd_t cmd, input logic [IDX_W-1:0] idx);
        result_t r;
        int used;
        bit hit;
        r = '0;
        used = bits_used();
        hit = 1'b0;
        if (cmd == CMD_FIND) begin
            for (int b = 0; b < used / 8; b++) begin
                if (!hit && alloc_map[b] != FULL_BYTE) begin
                    for (int k = 0; k < 8; k++) begin
                        if (!hit && !alloc_map[b][k]) begin
                            hit = 1'b1;
                            r.found_index = IDX_W'(b * 8 + k);
                        end
                    end
                end
            end
            if (!hit) begin
                r.status = ST_NONE;
            end
        end else if (int'(idx) >= used) begin
            r.status = ST_RANGE;
        end else begin
            case (cmd)
                CMD_SET: begin
                    alloc_map[idx[IDX_W-1:3]][idx[2:0]] = 1'b1;
                end
                CMD_CLEAR: begin
                    alloc_map[idx[IDX_W-1:3]][idx[2:0]] = 1'b0;
                end
                default: begin
                    r.bit_value = alloc_map[idx[IDX_W-1:3]][idx[2:0]];
                end
            endcase
        end
        return r;
    endfunction

    function automatic int pick_gap(input bit no_idle);
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input cmd_t cmd, input logic [IDX_W-1:0] idx, input bit typed,
                             input result_t want, output result_t predicted);
        int gap;
        s_valid <= 1'b1;
        s_command <= cmd;
        s_bit_index <= idx;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predicted = bitmap_apply(cmd, idx);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
        gap = pick_gap(steady);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_bit_count(input logic [COUNT_W-1:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        model_count = value;
        cfg_wr_en <= 1'b0;
    endtask

    // Receiver with random back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if (!steady && $urandom_range(0, 2) == 0) begin
                stall_left = pick_gap(1'b0);
            end
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: result transfer with nothing expected (value %0d index %0d status %0d)",
                         $time, m_bit_value, m_found_index, m_status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_bit_value !== want.bit_value) begin
                    $display("%0t: bit_value expected %0d, got %0d",
                             $time, want.bit_value, m_bit_value);
                    errors++;
                end
                if (m_found_index !== want.found_index) begin
                    $display("%0t: found_index expected %0d, got %0d",
                             $time, want.found_index, m_found_index);
                    errors++;
                end
                if (m_status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d", $time, want.status, m_status);
                    errors++;
                end
            end
            if (m_status === ST_NONE) begin
                none_free_seen++;
            end
            if (m_status === ST_RANGE) begin
                range_seen++;
            end
        end
        if (aresetn && s_valid && s_ready && s_command == CMD_FIND) begin
            finds_seen++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [COUNT_W-1:0] phase_counts [N_PHASES];
        result_t predicted;
        int used;
        int choice;
        int sent_in_phase;
        cmd_t cmd;
        logic [IDX_W-1:0] idx;

        phase_counts = '{13'd8, 13'd16, 13'd4095, 13'd3, 13'd64, 13'd4096, 13'd23, 13'h1fff,
                         13'd0, 13'd32};
        phase_counts[8] = COUNT_W'($urandom_range(8, 4096));
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_command = CMD_SET;
        s_bit_index = '0;
        m_ready = 1'b0;
        steady = 1'b0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        finds_seen = 0;
        none_free_seen = 0;
        range_seen = 0;
        idle_cycles = 0;
        stall_left = 0;
        model_count = 13'd4096;
        for (int b = 0; b < STORE_BYTES; b++) begin
            alloc_map[b] = 8'h00;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].is_cfg) begin
                write_bit_count(DIRECTED[i].cfg_value);
            end else begin
                send_item(DIRECTED[i].cmd, DIRECTED[i].idx, DIRECTED[i].typed,
                          DIRECTED[i].want, predicted);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            write_bit_count(phase_counts[p]);
            steady = (p % 4 == 3);
            sent_in_phase = 0;
            while (sent_in_phase < PHASE_ITEMS) begin
                used = bits_used();
                choice = $urandom_range(0, 99);
                idx = IDX_W'($urandom_range(0, used + 15 > 4095 ? 4095 : used + 15));
                if (choice < 35) begin
                    // Allocation: find the lowest free bit, then claim it.
                    send_item(CMD_FIND, IDX_W'($urandom()), 1'b0, '0, predicted);
                    sent_in_phase++;
                    if (predicted.status == ST_OK) begin
                        send_item(CMD_SET, predicted.found_index, 1'b0, '0, predicted);
                        sent_in_phase++;
                    end
                end else begin
                    if (choice < 55) begin
                        cmd = CMD_SET;
                    end else if (choice < 75) begin
                        cmd = CMD_CLEAR;
                    end else if (choice < 90) begin
                        cmd = CMD_READ;
                    end else if (choice < 95) begin
                        cmd = CMD_FIND;
                    end else begin
                        cmd = cmd_t'($urandom_range(0, 3));
                        idx = IDX_W'($urandom_range(0, 4095));
                    end
                    send_item(cmd, idx, 1'b0, '0, predicted);
                    sent_in_phase++;
                end
                if ($urandom_range(0, 99) == 0) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Sent %0d commands over %0d bit-count settings; %0d results checked.",
                 items_sent, N_PHASES + 3, results_seen);
        $display("Finds: %0d, none-free results: %0d, out-of-range results: %0d.",
                 finds_seen, none_free_seen, range_seen);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
